// ===== rtl/core/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
// No dependencies; imported by cdq_ram, cdq_ctrl and circular_deque.
package cdq_pkg;

  localparam int WORD_W    = 32;
  localparam int CAP_W     = 11;
  localparam int CMD_W     = 3;
  localparam int DEPTH_DEF = 1024;

  localparam logic [CAP_W-1:0]         CAP_RESET  = CAP_W'(1024);
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_REAR  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_REAR  = 3'd3,
    CMD_QUERY     = 3'd4
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_FIN  = 1'b1
  } state_e;

  typedef struct packed {
    logic                     accepted;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [CAP_W-1:0]         occupancy;
  } cdq_result_t;

endpackage

// ===== rtl/core/circular_deque.sv =====
// Top level of the circular deque: capacity register, output register and wiring.
// Depends on cdq_pkg, cdq_ram and cdq_ctrl.
//
// Usage. Each input transfer (in_valid_i high, in_stall_o low) carries a command
// and a word: insert at the front, insert at the rear, delete from the front,
// delete from the rear, or query. Every command yields exactly one result
// transfer on the output channel (out_valid_o high, out_stall_i low) reporting
// whether the command was performed and the front word, rear word, empty and
// full flags and occupancy afterwards; an empty deque shows -1 at both ends.
// The capacity register is written through cfg_valid_i and cfg_data_i, which is
// always ready; it should only be written while no command is in flight.
// A new command is not taken until the result of the last one has been passed to
// the output register: the command is applied in the cycle of its transfer, and
// the result waits in ST_FIN on the registered read of the ring memory that
// fetches the new end word after a delete. From ST_FIN the result is loaded into
// the output register, from which it can leave. While the receiver stalls with a result
// pending, the next command is still taken and its result is held back until the
// output register frees up; the input then stalls until that happens.
// Reset empties the deque and sets the capacity to 1024; the ring memory is not
// cleared, since a word read from an unoccupied entry is never shown.
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cdq_pkg::CAP_W-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cdq_pkg::CMD_W-1:0]          cmd_i,
  input  logic signed [cdq_pkg::WORD_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              accepted_o,
  output logic signed [cdq_pkg::WORD_W-1:0]  front_value_o,
  output logic signed [cdq_pkg::WORD_W-1:0]  rear_value_o,
  output logic                              is_empty_o,
  output logic                              is_full_o,
  output logic [cdq_pkg::CAP_W-1:0]          occupancy_o
);
  import cdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CAP_W-1:0]         cap_q;
  logic                     out_valid_q, out_valid_d;
  cdq_result_t              out_q, res;
  logic                     res_valid, res_ready;
  logic                     we, re;
  logic [AW-1:0]            waddr, raddr;
  logic signed [WORD_W-1:0] wdata, rdata;

  // The capacity register takes every write at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  cdq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .cap_i       (cap_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  // The output register accepts a new result when it is empty or is being
  // drained in the same cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = out_q.accepted;
  assign front_value_o = out_q.front_value;
  assign rear_value_o  = out_q.rear_value;
  assign is_empty_o    = out_q.is_empty;
  assign is_full_o     = out_q.is_full;
  assign occupancy_o   = out_q.occupancy;

  // After a command transfer the input is stalled while its result is pending, whatever the command.
  a_stall_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("command taken on consecutive cycles");

  // The empty flag agrees with the occupancy.
  a_empty_matches_count : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (occupancy_o == '0))
  ) else $error("empty flag disagrees with occupancy");

  // An empty deque shows -1 at both ends.
  a_empty_ends : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |->
      ((front_value_o == EMPTY_WORD) && (rear_value_o == EMPTY_WORD))
  ) else $error("empty deque shows a stored word");

endmodule

// ===== rtl/core/cdq_ram.sv =====
// Ring store of the circular deque: one write port and one registered read port.
// Depends on cdq_pkg for the word width.
module cdq_ram #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic signed [cdq_pkg::WORD_W-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [AW-1:0]                    raddr_i,
  output logic signed [cdq_pkg::WORD_W-1:0] rdata_o
);
  import cdq_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cdq_ctrl.sv =====
// Pointer, count and end-word cache control of the circular deque.
// Depends on cdq_pkg; drives the ports of cdq_ram.
module cdq_ctrl #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cdq_pkg::CMD_W-1:0]          cmd_i,
  input  logic signed [cdq_pkg::WORD_W-1:0]  value_i,
  input  logic [cdq_pkg::CAP_W-1:0]          cap_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output cdq_pkg::cdq_result_t              res_o,
  output logic                              we_o,
  output logic [AW-1:0]                     waddr_o,
  output logic signed [cdq_pkg::WORD_W-1:0]  wdata_o,
  output logic                              re_o,
  output logic [AW-1:0]                     raddr_o,
  input  logic signed [cdq_pkg::WORD_W-1:0]  rdata_i
);
  import cdq_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  state_e                   state_q, state_d;
  logic [AW-1:0]            head_q, head_d, tail_q, tail_d;
  logic [CAP_W-1:0]         count_q, count_d;
  logic signed [WORD_W-1:0] front_q, front_d, rear_q, rear_d;
  logic                     ok_q, ok_d;
  logic                     rd_front_q, rd_front_d, rd_rear_q, rd_rear_d;
  logic                     accept;
  logic [CAP_W-1:0]         eff_cap;
  logic                     full, empty;
  logic [AW-1:0]            head_inc, head_dec, tail_inc, tail_dec, tail_dec2;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST : p - AW'(1);
  endfunction

  // A capacity above the ring depth behaves as the depth.
  assign eff_cap = (32'(cap_i) > 32'(DEPTH)) ? CAP_W'(DEPTH) : cap_i;
  assign full    = count_q >= eff_cap;
  assign empty   = count_q == '0;

  assign head_inc  = wrap_inc(head_q);
  assign head_dec  = wrap_dec(head_q);
  assign tail_inc  = wrap_inc(tail_q);
  assign tail_dec  = wrap_dec(tail_q);
  assign tail_dec2 = wrap_dec(tail_dec);

  assign accept = (state_q == ST_IDLE) && in_valid_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall_o          = 1'b1;
    res_valid_o         = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o  = 1'b0;
      ST_FIN:  res_valid_o = 1'b1;
      default: in_stall_o  = 1'b1;
    endcase
    res_o.accepted    = ok_q;
    res_o.is_empty    = empty;
    res_o.is_full     = full;
    res_o.occupancy   = count_q;
    res_o.front_value = empty ? EMPTY_WORD : (rd_front_q ? rdata_i : front_q);
    res_o.rear_value  = empty ? EMPTY_WORD : (rd_rear_q ? rdata_i : rear_q);
  end

  // Datapath: the operation is applied in the transfer cycle; a delete fetches
  // the new end word, which is folded into the cache when the output register takes the result.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    front_d    = front_q;
    rear_d     = rear_q;
    ok_d       = ok_q;
    rd_front_d = rd_front_q;
    rd_rear_d  = rd_rear_q;
    we_o       = 1'b0;
    waddr_o    = head_dec;
    wdata_o    = value_i;
    re_o       = 1'b0;
    raddr_o    = head_inc;
    if (accept) begin
      ok_d       = 1'b1;
      rd_front_d = 1'b0;
      rd_rear_d  = 1'b0;
      case (cmd_e'(cmd_i))
        CMD_INS_FRONT: begin
          if (full) begin
            ok_d = 1'b0;
          end else begin
            we_o    = 1'b1;
            waddr_o = head_dec;
            head_d  = head_dec;
            count_d = count_q + CAP_W'(1);
            front_d = value_i;
            if (empty) begin
              rear_d = value_i;
            end
          end
        end
        CMD_INS_REAR: begin
          if (full) begin
            ok_d = 1'b0;
          end else begin
            we_o    = 1'b1;
            waddr_o = tail_q;
            tail_d  = tail_inc;
            count_d = count_q + CAP_W'(1);
            rear_d  = value_i;
            if (empty) begin
              front_d = value_i;
            end
          end
        end
        CMD_DEL_FRONT: begin
          if (empty) begin
            ok_d = 1'b0;
          end else begin
            re_o       = 1'b1;
            raddr_o    = head_inc;
            head_d     = head_inc;
            count_d    = count_q - CAP_W'(1);
            rd_front_d = 1'b1;
          end
        end
        CMD_DEL_REAR: begin
          if (empty) begin
            ok_d = 1'b0;
          end else begin
            re_o      = 1'b1;
            raddr_o   = tail_dec2;
            tail_d    = tail_dec;
            count_d   = count_q - CAP_W'(1);
            rd_rear_d = 1'b1;
          end
        end
        default: ok_d = 1'b1;
      endcase
    end else if ((state_q == ST_FIN) && res_ready_i) begin
      if (rd_front_q) begin
        front_d = rdata_i;
      end
      if (rd_rear_q) begin
        rear_d = rdata_i;
      end
      rd_front_d = 1'b0;
      rd_rear_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      ok_q       <= 1'b0;
      rd_front_q <= 1'b0;
      rd_rear_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      ok_q       <= ok_d;
      rd_front_q <= rd_front_d;
      rd_rear_q  <= rd_rear_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    rear_q  <= rear_d;
  end

endmodule
